// File: sv/fixed_slot_pool_allocator_macros.svh
// Assertion macros shared by the slot pool allocator RTL.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define FSPA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fspa check failed");

// Consequent must hold in the cycle after the antecedent
`define FSPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fspa check failed");

`else

`define FSPA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define FSPA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: sv/fspa_pkg.sv
// Shared types, constants and helpers for the fixed slot pool allocator.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps

package fspa_pkg;

   // Field widths
   localparam int ADDR_W    = 48;
   localparam int STRIDE_W  = 21;
   localparam int COUNT_W   = 11;
   localparam int CSR_DW    = 64;
   localparam int PADDR_W   = 5;
   localparam int DEF_SLOTS = 1024;

   // Busy map word organization
   localparam int WORD_BITS = 32;
   localparam int WBIT_W    = 5;

   // Step counter of the shift/add unit (covers ADDR_W steps)
   localparam int DM_CNT_W  = 6;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_START = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

   // Register index, taken from paddr[4:3]
   typedef enum logic [1:0] {
      REG_BASE   = 2'd0,
      REG_STRIDE = 2'd1,
      REG_COUNT  = 2'd2
   } reg_idx_type;

   typedef enum logic {
      DM_DIV = 1'b0,
      DM_MUL = 1'b1
   } dm_mode_type;

   typedef struct packed {
      op_type              operation;
      logic [ADDR_W-1:0]   address;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   slot_address;
      status_type          status;
   } rsp_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   base_address;
      logic [STRIDE_W-1:0] slot_stride;
      logic [COUNT_W-1:0]  slot_count;
   } cfg_type;

   typedef struct packed {
      logic        start;
      dm_mode_type mode;
   } dm_ctl_type;

   // Number of busy map words for a pool of the given depth
   function automatic int fspa_words(input int slots);
      return (slots + WORD_BITS - 1) / WORD_BITS;
   endfunction

   // Index width for n entries, never below one bit
   function automatic int fspa_idx_w(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

// File: sv/fspa_cfg_regs.sv
// APB-style configuration registers of the slot pool allocator.
// Depends on fspa_pkg.
`timescale 1ns / 1ps

module fspa_cfg_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fspa_pkg::PADDR_W-1:0]   paddr,
   input  logic [fspa_pkg::CSR_DW-1:0]    pwdata,
   output logic [fspa_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready,
   output fspa_pkg::cfg_type              cfg
);
   import fspa_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign cfg    = cfg_ff;

   // Register write decode; unmapped slots are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[4:3])
            REG_BASE:   cfg_in.base_address = pwdata[ADDR_W-1:0];
            REG_STRIDE: cfg_in.slot_stride  = pwdata[STRIDE_W-1:0];
            REG_COUNT:  cfg_in.slot_count   = pwdata[COUNT_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (paddr[4:3])
         REG_BASE:   prdata = CSR_DW'(cfg_ff.base_address);
         REG_STRIDE: prdata = CSR_DW'(cfg_ff.slot_stride);
         REG_COUNT:  prdata = CSR_DW'(cfg_ff.slot_count);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= '0;
         cfg_ff.slot_stride  <= STRIDE_W'(1);
         cfg_ff.slot_count   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/fspa_busy_map.sv
// Busy map storage: one bit per slot, packed into 32-bit words.
// One write port, one read port with registered data. Depends on fspa_pkg.
`timescale 1ns / 1ps

module fspa_busy_map #(
   parameter int SLOTS = fspa_pkg::DEF_SLOTS
) (
   input  logic                                                clock,
   input  logic                                                wr_en,
   input  logic [fspa_pkg::fspa_idx_w(fspa_pkg::fspa_words(SLOTS))-1:0] wr_addr,
   input  logic [fspa_pkg::WORD_BITS-1:0]                      wr_data,
   input  logic [fspa_pkg::fspa_idx_w(fspa_pkg::fspa_words(SLOTS))-1:0] rd_addr,
   output logic [fspa_pkg::WORD_BITS-1:0]                      rd_data
);
   import fspa_pkg::*;

   localparam int WORDS = fspa_words(SLOTS);

   logic [WORD_BITS-1:0] mem_ff [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// File: sv/fspa_divmul.sv
// Bit-serial shift/add unit: restoring divide (offset / stride) or
// shift-add multiply (stride * slot index) over one shared 48-bit adder.
// Depends on fspa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fixed_slot_pool_allocator_macros.svh"

module fspa_divmul #(
   parameter int IDX_W = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fspa_pkg::dm_ctl_type            ctl,
   input  logic [fspa_pkg::ADDR_W-1:0]     dividend,
   input  logic [fspa_pkg::STRIDE_W-1:0]   divisor,
   input  logic [IDX_W-1:0]                mul_idx,
   output logic                            done,
   output logic [fspa_pkg::ADDR_W-1:0]     quot,
   output logic [fspa_pkg::STRIDE_W-1:0]   rem
);
   import fspa_pkg::*;

   localparam int REM_W = STRIDE_W + 1;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   dm_mode_type         mode_ff, mode_in;
   logic [DM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   acc_ff, acc_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ADDR_W-1:0]   opnd_ff, opnd_in;
   logic [STRIDE_W-1:0] dsr_ff, dsr_in;

   logic [REM_W-1:0]    shifted;
   logic [ADDR_W-1:0]   add_a, add_b;
   logic                add_sub;
   logic [ADDR_W:0]     sum;

   assign done = done_ff;
   assign quot = acc_ff;
   assign rem  = rem_ff[STRIDE_W-1:0];

   // Shared adder: trial subtract for divide, accumulate for multiply
   always_comb begin
      shifted = {rem_ff[REM_W-2:0], opnd_ff[ADDR_W-1]};
      if (mode_ff == DM_DIV) begin
         add_a   = ADDR_W'(shifted);
         add_b   = ADDR_W'(dsr_ff);
         add_sub = 1'b1;
      end else begin
         add_a   = {acc_ff[ADDR_W-2:0], 1'b0};
         add_b   = opnd_ff[ADDR_W-1] ? ADDR_W'(dsr_ff) : '0;
         add_sub = 1'b0;
      end
      sum = {1'b0, add_a} + {1'b0, add_b ^ {ADDR_W{add_sub}}} + (ADDR_W + 1)'(add_sub);
   end

   // Sequencing: load on start, one bit per cycle, pulse done at the end
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      opnd_in = opnd_ff;
      dsr_in  = dsr_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         dsr_in  = divisor;
         acc_in  = '0;
         rem_in  = '0;
         if (ctl.mode == DM_DIV) begin
            opnd_in = dividend;
            cnt_in  = DM_CNT_W'(ADDR_W - 1);
         end else begin
            // multiplier bits left-aligned so they leave at the top
            opnd_in = ADDR_W'(mul_idx) << (ADDR_W - IDX_W);
            cnt_in  = DM_CNT_W'(IDX_W - 1);
         end
      end else if (busy_ff) begin
         opnd_in = {opnd_ff[ADDR_W-2:0], 1'b0};
         if (mode_ff == DM_DIV) begin
            if (sum[ADDR_W]) begin
               rem_in = sum[REM_W-1:0];
               acc_in = {acc_ff[ADDR_W-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               acc_in = {acc_ff[ADDR_W-2:0], 1'b0};
            end
         end else begin
            acc_in = sum[ADDR_W-1:0];
         end
         cnt_in = cnt_ff - DM_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      opnd_ff <= opnd_in;
      dsr_ff  <= dsr_in;
   end

   // Checks
   `FSPA_ASSERT_NEXT(a_start_busy, clock, reset, ctl.start, busy_ff)
   `FSPA_ASSERT_IMPLIES(a_done_idle, clock, reset, done_ff, !busy_ff)
   `FSPA_ASSERT_IMPLIES(a_rem_below_div, clock, reset, done_ff && (mode_ff == DM_DIV) && (dsr_ff != '0), rem_ff < REM_W'(dsr_ff))

endmodule

// File: sv/fixed_slot_pool_allocator.sv
// Fixed slot pool allocator: hands out equal-size slots at base + stride * index.
// After reset the busy map is cleared one 32-bit word per cycle (SLOTS/32 words,
// 32 for 1024 slots) and no request is taken meanwhile. One request is in flight
// at a time. An allocate scans the busy map one word per cycle, then forms the
// slot address with the bit-serial multiplier; the scan stops at the first word
// with a free slot. A full pool answers once the last word is checked, and a
// pool with no slots answers without a scan. A free runs the 48-step bit-serial
// divider and a read-modify-write of one word; a rejected address skips the
// read-modify-write. The next request is taken in the cycle after the response
// is loaded; a response waits in ST_RESP while an earlier one is still held
// off. The user must write configuration only while idle; the block does not
// enforce it.
// Depends on fspa_pkg, fspa_cfg_regs, fspa_busy_map, fspa_divmul and the macros.
`timescale 1ns / 1ps
`include "fixed_slot_pool_allocator_macros.svh"

module fixed_slot_pool_allocator #(
   parameter int SLOTS = fspa_pkg::DEF_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fspa_pkg::req_payload_type      req_payload,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fspa_pkg::rsp_payload_type      rsp_payload,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fspa_pkg::PADDR_W-1:0]   paddr,
   input  logic [fspa_pkg::CSR_DW-1:0]    pwdata,
   output logic [fspa_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready
);
   import fspa_pkg::*;

   localparam int WORDS   = fspa_words(SLOTS);
   localparam int WADDR_W = fspa_idx_w(WORDS);
   localparam int IDX_W   = fspa_idx_w(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_SCAN_RD  = 9'b000000100,
      ST_SCAN_CHK = 9'b000001000,
      ST_MUL      = 9'b000010000,
      ST_DIV      = 9'b000100000,
      ST_FREE_RD  = 9'b001000000,
      ST_FREE_WR  = 9'b010000000,
      ST_RESP     = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [WADDR_W-1:0] clr_ff, clr_in;
   logic [WADDR_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   status_type         res_status_ff, res_status_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   cfg_type             cfg;
   logic [STRIDE_W-1:0] eff_stride;
   logic [CNT_W-1:0]    eff_count;

   logic                 bm_wr_en;
   logic [WADDR_W-1:0]   bm_wr_addr, bm_rd_addr;
   logic [WORD_BITS-1:0] bm_wr_data, bm_rd_data;

   dm_ctl_type          dm_ctl;
   logic                dm_done;
   logic [ADDR_W-1:0]   dm_quot;
   logic [STRIDE_W-1:0] dm_rem;
   logic [ADDR_W-1:0]   offset;

   logic [WORD_BITS-1:0] valid_bits, masked;
   logic                 found, last_word;
   logic [WBIT_W-1:0]    pos;
   logic [IDX_W-1:0]     scan_idx;
   logic [WADDR_W-1:0]   word_nxt, free_word;
   logic [WBIT_W-1:0]    free_bit;

   // Configuration registers
   fspa_cfg_regs u_cfg (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Busy map
   fspa_busy_map #(.SLOTS(SLOTS)) u_map (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   // Shared divide / multiply unit
   fspa_divmul #(.IDX_W(IDX_W)) u_dm (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dm_ctl),
      .dividend (offset),
      .divisor  (eff_stride),
      .mul_idx  (scan_idx),
      .done     (dm_done),
      .quot     (dm_quot),
      .rem      (dm_rem)
   );

   // Effective configuration: zero stride acts as one, count saturates
   assign eff_stride = (cfg.slot_stride == '0) ? STRIDE_W'(1) : cfg.slot_stride;
   assign eff_count  = (32'(cfg.slot_count) > SLOTS) ? CNT_W'(SLOTS)
                                                     : CNT_W'(cfg.slot_count);
   assign offset     = req_payload.address - cfg.base_address;

   // Word scan: slots past the count look busy, pick the lowest free bit
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_bits[b] = 32'(remain_ff) > b;
      end
      masked = bm_rd_data | ~valid_bits;
      found  = ~&masked;
      pos    = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!masked[b]) begin
            pos = WBIT_W'(b);
         end
      end
      scan_idx  = IDX_W'((32'(word_ff) << WBIT_W) | 32'(pos));
      last_word = 32'(remain_ff) <= WORD_BITS;
      word_nxt  = word_ff + WADDR_W'(1);
      free_word = WADDR_W'(32'(idx_ff) >> WBIT_W);
      free_bit  = WBIT_W'(32'(idx_ff));
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      word_in       = word_ff;
      remain_in     = remain_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      bm_wr_en      = 1'b0;
      bm_wr_addr    = word_ff;
      bm_wr_data    = '0;
      bm_rd_addr    = word_ff;
      dm_ctl.start  = 1'b0;
      dm_ctl.mode   = DM_DIV;

      // response transfer drains the output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            bm_wr_en   = 1'b1;
            bm_wr_addr = clr_ff;
            clr_in     = clr_ff + WADDR_W'(1);
            if (clr_ff == WADDR_W'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_addr_in = '0;
               if (req_payload.operation == OP_ALLOC) begin
                  if (eff_count == '0) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_RESP;
                  end else begin
                     word_in   = '0;
                     remain_in = eff_count;
                     state_in  = ST_SCAN_RD;
                  end
               end else begin
                  dm_ctl.start = 1'b1;
                  dm_ctl.mode  = DM_DIV;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            // fetch the next word ahead in case this one is full
            bm_rd_addr = word_nxt;
            if (found) begin
               bm_wr_en     = 1'b1;
               bm_wr_data   = bm_rd_data | (WORD_BITS'(1) << pos);
               idx_in       = scan_idx;
               dm_ctl.start = 1'b1;
               dm_ctl.mode  = DM_MUL;
               state_in     = ST_MUL;
            end else if (last_word) begin
               res_status_in = STATUS_FULL;
               state_in      = ST_RESP;
            end else begin
               word_in   = word_nxt;
               remain_in = remain_ff - CNT_W'(WORD_BITS);
            end
         end
         ST_MUL: begin
            if (dm_done) begin
               res_addr_in   = cfg.base_address + dm_quot;
               res_status_in = STATUS_OK;
               state_in      = ST_RESP;
            end
         end
         ST_DIV: begin
            if (dm_done) begin
               if (dm_quot >= ADDR_W'(eff_count)) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_RESP;
               end else if (dm_rem != '0) begin
                  res_status_in = STATUS_NOT_START;
                  state_in      = ST_RESP;
               end else begin
                  idx_in   = dm_quot[IDX_W-1:0];
                  state_in = ST_FREE_RD;
               end
            end
         end
         ST_FREE_RD: begin
            bm_rd_addr = free_word;
            state_in   = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            bm_wr_en      = 1'b1;
            bm_wr_addr    = free_word;
            bm_wr_data    = bm_rd_data & ~(WORD_BITS'(1) << free_bit);
            res_status_in = STATUS_OK;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.slot_address = res_addr_ff;
               rsp_data_in.status       = res_status_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff       <= word_in;
      remain_ff     <= remain_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Checks
   `FSPA_ASSERT_IMPLIES(a_map_write_state, clock, reset, bm_wr_en, (state_ff == ST_SCAN_CHK) || (state_ff == ST_FREE_WR) || (state_ff == ST_CLEAR))
   `FSPA_ASSERT_IMPLIES(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_RESP))
   `FSPA_ASSERT_IMPLIES(a_err_zero_addr, clock, reset, rsp_valid_ff && (rsp_data_ff.status != STATUS_OK), rsp_data_ff.slot_address == '0)
   `FSPA_ASSERT_IMPLIES(a_dm_done_state, clock, reset, dm_done, (state_ff == ST_DIV) || (state_ff == ST_MUL))

endmodule
